### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define AMT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define AMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/amt_pkg.sv
// ----------------------------------------------------------------------------
// amt_pkg
// Shared types and constants of the 3x3 adaptive mean threshold block.
// ----------------------------------------------------------------------------
`default_nettype none

package amt_pkg;

    // Line width limit and line store word
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int LS_WORD_BITS  = 16;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int FRAME_W_BITS   = 11;
    localparam int FRAME_H_BITS   = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [FRAME_W_BITS-1:0] FRAME_W_RESET = 11'd640;
    localparam logic [FRAME_H_BITS-1:0] FRAME_H_RESET = 16'd480;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Binarised output levels
    localparam logic [7:0] PIX_ON  = 8'd255;
    localparam logic [7:0] PIX_OFF = 8'd0;

    typedef logic [7:0] pix_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0] bin_pixel;
        logic       end_of_frame;
    } out_word_t;

    // Which neighbours of a result pixel lie inside the frame
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } border_t;

endpackage

`default_nettype wire

### hw/rtl/amt_ram.sv
// ----------------------------------------------------------------------------
// amt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module amt_ram #(
    parameter int WIDTH = amt_pkg::LS_WORD_BITS,
    parameter int DEPTH = amt_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/adaptive_mean_threshold_3x3.sv
// ----------------------------------------------------------------------------
// adaptive_mean_threshold_3x3
// Binarises a raster stream of grey pixels against the mean of each pixel's
// 3x3 neighbourhood (outside neighbours count as zero, divisor always 9).
// ----------------------------------------------------------------------------
// The block takes one word per clock while in_stall is low, pixels or flush
// ticks alike, and a result leaves through stage 1, stage 2 and the output
// FIFO once a word releases it; the result for pixel k is released by
// word k+W+1, so W+1 flush words drain a frame and the last result carries
// end_of_frame. The line store RAM is read, updated and written back once
// per column, with a forwarding path for narrow frames. Results queue in a
// four-word output FIFO; in_stall rises once the queued results plus the
// words in the two pipeline stages reach four, so under a stalled output the
// input can stop before the FIFO itself is full.
// The line store needs no clearing pass after reset.
// A register write restarts the frame and must only happen while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_mean_threshold_3x3 #(
    parameter int MAX_WIDTH = amt_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [amt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [amt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire amt_pkg::in_word_t                   in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output amt_pkg::out_word_t                       out_data
);

    localparam int ADDR_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W      = amt_pkg::FRAME_H_BITS + 1;
    localparam int SUM_W      = 12;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1) + 1;

    // ------------------------------------------------------------------
    // Configuration registers and frame geometry
    // ------------------------------------------------------------------
    logic [amt_pkg::FRAME_W_BITS-1:0] frame_width_reg;
    logic [amt_pkg::FRAME_H_BITS-1:0] frame_height_reg;
    logic                             restart;
    logic [ADDR_W-1:0]                width_m1;
    logic [amt_pkg::FRAME_H_BITS-1:0] height_m1;

    assign restart = cfg_write && ((cfg_index == amt_pkg::REG_FRAME_WIDTH) ||
                                   (cfg_index == amt_pkg::REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= amt_pkg::FRAME_W_RESET;
            frame_height_reg <= amt_pkg::FRAME_H_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                amt_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[amt_pkg::FRAME_W_BITS-1:0];
                amt_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[amt_pkg::FRAME_H_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // Clamp the width to 1..MAX_WIDTH and take a zero height as one
    always_comb
    begin
        if (frame_width_reg == '0)
            width_m1 = '0;
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            width_m1 = ADDR_W'(MAX_WIDTH - 1);
        else
            width_m1 = ADDR_W'(frame_width_reg - 11'd1);

        if (frame_height_reg == '0)
            height_m1 = '0;
        else
            height_m1 = frame_height_reg - 16'd1;
    end

    // ------------------------------------------------------------------
    // Entry: frame position counters and result position counters
    // ------------------------------------------------------------------
    logic                             in_take;
    logic                             in_acc;
    logic                             frame_full;
    logic                             s0_emit;
    logic                             s0_last;
    logic                             col_end;
    logic                             ecol_end;
    logic                             erow_end;
    amt_pkg::border_t                 s0_border;
    amt_pkg::pix_t                    s0_pix;

    logic [ADDR_W-1:0]                col_reg;
    logic [ROW_W-1:0]                 row_reg;
    logic [ADDR_W-1:0]                ecol_reg;
    logic [amt_pkg::FRAME_H_BITS-1:0] erow_reg;

    assign in_acc     = in_valid && !in_stall;
    assign frame_full = row_reg > {1'b0, height_m1};
    assign in_take    = in_acc && ((in_data.cmd == amt_pkg::CMD_PIXEL) ? !frame_full
                                                                       : frame_full);
    assign s0_pix     = (in_data.cmd == amt_pkg::CMD_PIXEL) ? in_data.pixel_in : 8'd0;

    // Results start once the first W+1 words are in
    assign s0_emit  = !((row_reg == '0) || ((row_reg == ROW_W'(1)) && (col_reg == '0)));
    assign col_end  = (col_reg == width_m1);
    assign ecol_end = (ecol_reg == width_m1);
    assign erow_end = (erow_reg == height_m1);
    assign s0_last  = s0_emit && ecol_end && erow_end;

    assign s0_border.top_ok   = (erow_reg != '0);
    assign s0_border.bot_ok   = !erow_end;
    assign s0_border.left_ok  = (ecol_reg != '0);
    assign s0_border.right_ok = !ecol_end;

    // Advance the counters; restart the frame after its last result or on a frame register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ecol_reg <= '0;
            erow_reg <= '0;
        end
        else if (restart)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ecol_reg <= '0;
            erow_reg <= '0;
        end
        else if (in_take)
        begin
            if (s0_last)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                ecol_reg <= '0;
                erow_reg <= '0;
            end
            else
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + ADDR_W'(1);
                end

                if (s0_emit)
                begin
                    if (ecol_end)
                    begin
                        ecol_reg <= '0;
                        erow_reg <= erow_reg + 16'd1;
                    end
                    else
                    begin
                        ecol_reg <= ecol_reg + ADDR_W'(1);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read-modify-write and window shift
    // ------------------------------------------------------------------
    logic                                 s1_valid_reg;
    logic                                 s1_emit_reg;
    logic                                 s1_last_reg;
    amt_pkg::border_t                     s1_border_reg;
    logic [ADDR_W-1:0]                    s1_addr_reg;
    amt_pkg::pix_t                        s1_pix_reg;
    logic                                 fwd_hit_reg;
    logic [amt_pkg::LS_WORD_BITS-1:0]     fwd_data_reg;
    logic                                 fwd_hit_next;
    logic [amt_pkg::LS_WORD_BITS-1:0]     ram_rdata;
    logic [amt_pkg::LS_WORD_BITS-1:0]     ls_word;
    logic [amt_pkg::LS_WORD_BITS-1:0]     ram_wdata;
    amt_pkg::pix_t                        ls_top;
    amt_pkg::pix_t                        ls_mid;
    amt_pkg::pix_t                        win_reg  [9];
    amt_pkg::pix_t                        win_next [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_emit_reg   <= s0_emit;
        s1_last_reg   <= s0_last;
        s1_border_reg <= s0_border;
        s1_addr_reg   <= col_reg;
        s1_pix_reg    <= s0_pix;
        fwd_hit_reg   <= fwd_hit_next;
        fwd_data_reg  <= ram_wdata;
    end

    // Forward the word written in the same cycle the next read is issued
    assign fwd_hit_next = s1_valid_reg && (s1_addr_reg == col_reg);

    // Each word holds {two rows back, one row back} for its column
    assign ls_word   = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign ls_top    = ls_word[15:8];
    assign ls_mid    = ls_word[7:0];
    assign ram_wdata = {ls_mid, s1_pix_reg};

    amt_ram #(
        .WIDTH (amt_pkg::LS_WORD_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // Shift the window left and take the new column on the right
    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = ls_top;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = ls_mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (restart || (s1_valid_reg && s1_last_reg))
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (s1_valid_reg)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= win_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: masked neighbourhood sum and threshold compare
    // ------------------------------------------------------------------
    logic              s2_valid_reg;
    logic              s2_last_reg;
    amt_pkg::border_t  s2_border_reg;
    amt_pkg::pix_t     s2_win_reg [9];
    amt_pkg::pix_t     term       [9];
    logic [SUM_W-1:0]  row_sum    [3];
    logic [SUM_W-1:0]  nb_sum;
    logic [SUM_W-1:0]  centre_x9;
    amt_pkg::out_word_t s2_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg   <= s1_last_reg;
        s2_border_reg <= s1_border_reg;
        for (int i = 0; i < 9; i++)
            s2_win_reg[i] <= win_next[i];
    end

    // Drop neighbours outside the frame
    always_comb
    begin
        logic row_ok;
        logic col_ok;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                row_ok = (r == 0) ? s2_border_reg.top_ok :
                         (r == 2) ? s2_border_reg.bot_ok : 1'b1;
                col_ok = (c == 0) ? s2_border_reg.left_ok :
                         (c == 2) ? s2_border_reg.right_ok : 1'b1;
                term[r*3 + c] = (row_ok && col_ok) ? s2_win_reg[r*3 + c] : 8'd0;
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            row_sum[r] = SUM_W'(term[r*3]) + SUM_W'(term[r*3 + 1]) + SUM_W'(term[r*3 + 2]);
        nb_sum = row_sum[0] + row_sum[1] + row_sum[2];
    end

    // centre >= floor(sum / 9)  <=>  9 * centre + 9 > sum
    assign centre_x9 = {1'b0, s2_win_reg[4], 3'b000} + SUM_W'(s2_win_reg[4]);

    always_comb
    begin
        s2_word.bin_pixel    = ((centre_x9 + SUM_W'(9)) > nb_sum) ? amt_pkg::PIX_ON
                                                                   : amt_pkg::PIX_OFF;
        s2_word.end_of_frame = s2_last_reg;
    end

    // ------------------------------------------------------------------
    // Output FIFO and input flow control
    // ------------------------------------------------------------------
    amt_pkg::out_word_t fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   committed;
    logic               push;
    logic               pop;

    assign push = s2_valid_reg;
    assign pop  = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= s2_word;
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = fifo_reg[rd_ptr_reg];

    // Hold input while queued results and words in flight fill the FIFO
    assign committed = count_reg + CNT_W'(s1_valid_reg) + CNT_W'(s2_valid_reg);
    assign in_stall  = (committed >= CNT_W'(FIFO_DEPTH));

endmodule

`default_nettype wire

### hw/rtl/amt_checker.sv
// ----------------------------------------------------------------------------
// amt_checker
// Port-level checks of the adaptive mean threshold block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module amt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire amt_pkg::in_word_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire amt_pkg::out_word_t out_data
);

    logic in_acc;

    assign in_acc = in_valid && !in_stall && (in_data.cmd == in_data.cmd);

    // Hold a stalled result word
    `AMT_ASSERT(a_out_valid_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "out_valid dropped while stalled")
    `AMT_ASSERT(a_out_data_hold, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "out_data changed while stalled")

    // Results are binary
    `AMT_ASSERT(a_bin_level, clk, rst_n, out_valid |-> (out_data.bin_pixel == amt_pkg::PIX_ON) || (out_data.bin_pixel == amt_pkg::PIX_OFF), "bin_pixel not 0 or 255")

    // A result reaching an empty output was released by an earlier accepted input word
    `AMT_ASSERT(a_out_latency, clk, rst_n, $rose(out_valid) |-> $past(in_acc, 3), "result without a releasing input word")

    // Nothing is left queued across a reset
    `AMT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result visible straight after reset")

endmodule

bind adaptive_mean_threshold_3x3 amt_checker u_amt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
